// File: rtl/lsvr_pkg.sv
// Shared types and constants for the Loop subdivision vertex rules block.
package lsvr_pkg;

	// Field and accumulator widths
	localparam int LSVR_COORD_W = 32;
	localparam int LSVR_PSUM_W  = 34;
	localparam int LSVR_SSUM_W  = 40;
	localparam int LSVR_PCNT_W  = 2;
	localparam int LSVR_SCNT_W  = 9;
	// weight fields sized for the widest fraction (24 bits), a full weight of one and a sign
	localparam int LSVR_WGT_W   = 26;
	localparam int LSVR_ACC_W   = 68;
	localparam int LSVR_QDEPTH  = 4;

	// Weight table build constants (Q3.30)
	localparam longint LSVR_TWO_PI_Q30 = 64'sd6746518852;
	localparam longint LSVR_Q30_ONE    = 64'sd1073741824;

	typedef logic signed [LSVR_COORD_W-1:0] lsvr_coord_t;
	typedef logic signed [LSVR_PSUM_W-1:0]  lsvr_psum_t;
	typedef logic signed [LSVR_SSUM_W-1:0]  lsvr_ssum_t;
	typedef logic signed [LSVR_ACC_W-1:0]   lsvr_acc_t;

	localparam lsvr_acc_t LSVR_SAT_MAX = lsvr_acc_t'(64'sd2147483647);
	localparam lsvr_acc_t LSVR_SAT_MIN = lsvr_acc_t'(-64'sd2147483648);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_VALENCE   = 2'd1,
		ST_MALFORMED = 2'd2
	} lsvr_status_t;

	// Rule picked for a finished group
	typedef enum logic [2:0] {
		OP_ZERO,
		OP_PASS,
		OP_BOUND,
		OP_INTERIOR,
		OP_MID,
		OP_ODD
	} lsvr_op_t;

	// Rounding shift picked by the back end
	typedef enum logic [1:0] {
		SH_0,
		SH_1,
		SH_3,
		SH_F
	} lsvr_shift_t;

	// One classified group, handed from front to back
	typedef struct packed {
		lsvr_op_t                      op;
		lsvr_status_t                  status;
		lsvr_psum_t  [2:0]             psum;
		lsvr_ssum_t  [2:0]             ssum;
		lsvr_coord_t [2:0]             first;
		lsvr_coord_t [2:0]             last;
		logic signed [LSVR_WGT_W-1:0]  w;
		logic signed [LSVR_WGT_W-1:0]  wc;
	} lsvr_job_t;

endpackage

// File: rtl/lsvr_ifs.sv
// Point and vertex channel interfaces.
interface lsvr_in_if import lsvr_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        mode;
	logic        role;
	logic        on_boundary;
	logic        group_end;
	lsvr_coord_t px;
	lsvr_coord_t py;
	lsvr_coord_t pz;

	modport source (output valid, mode, role, on_boundary, group_end, px, py, pz,
		input ready);
	modport sink (input valid, mode, role, on_boundary, group_end, px, py, pz,
		output ready);
endinterface

interface lsvr_out_if import lsvr_pkg::*; ();
	logic        valid;
	logic        ready;
	lsvr_coord_t rx;
	lsvr_coord_t ry;
	lsvr_coord_t rz;
	logic [1:0]  status;

	modport source (output valid, rx, ry, rz, status, input ready);
	modport sink (input valid, rx, ry, rz, status, output ready);
endinterface

// File: rtl/lsvr_front.sv
// Front end: accumulates group points and classifies each finished group.
module lsvr_front import lsvr_pkg::*; #(
	parameter int MAX_VALENCE      = 32,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	lsvr_in_if.sink   point,
	input  logic      algo_sel,
	input  logic      q_full,
	output logic      q_push,
	output lsvr_job_t q_job
);

	localparam int IDX_W = $clog2(MAX_VALENCE + 1);
	localparam int NW_W  = IDX_W + WEIGHT_FRAC_BITS;

	// Valence weight table, built at elaboration
	logic [WEIGHT_FRAC_BITS-1:0] rom [MAX_VALENCE+1];

	genvar Vi;
	generate
		for (Vi = 0; Vi <= MAX_VALENCE; Vi++) begin : g_rom
			if (Vi <= 3) begin : g_low
				assign rom[Vi] = WEIGHT_FRAC_BITS'(3 << (WEIGHT_FRAC_BITS - 4));
			end else begin : g_cos
				localparam longint X   = LSVR_TWO_PI_Q30 / Vi;
				localparam longint X2  = (X * X) >> 30;
				localparam longint T1  = ((LSVR_Q30_ONE * X2) >> 30) / 2;
				localparam longint T2  = ((T1 * X2) >> 30) / 12;
				localparam longint T3  = ((T2 * X2) >> 30) / 30;
				localparam longint T4  = ((T3 * X2) >> 30) / 56;
				localparam longint T5  = ((T4 * X2) >> 30) / 90;
				localparam longint T6  = ((T5 * X2) >> 30) / 132;
				localparam longint T7  = ((T6 * X2) >> 30) / 182;
				localparam longint CR  = LSVR_Q30_ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7;
				localparam longint C   = (CR < 0) ? 64'sd0 : CR;
				localparam longint B   = 64'sd402653184 + (C >> 2);
				localparam longint B2  = (B * B) >> 30;
				localparam longint A30 = (64'sd671088640 - B2) / Vi;
				localparam longint ENT = (A30 + (64'sd1 << (29 - WEIGHT_FRAC_BITS)))
					>> (30 - WEIGHT_FRAC_BITS);
				assign rom[Vi] = WEIGHT_FRAC_BITS'(ENT);
			end
		end
	endgenerate

	// Group state
	logic                   in_group_q;
	logic                   mode_q;
	logic                   bnd_q;
	logic [LSVR_PCNT_W-1:0] pcnt_q;
	logic [LSVR_SCNT_W-1:0] scnt_q;
	lsvr_psum_t             psum_q  [3];
	lsvr_ssum_t             ssum_q  [3];
	lsvr_coord_t            first_q [3];
	lsvr_coord_t            last_q  [3];

	logic                   accept;
	logic                   first_item;
	logic                   eff_mode;
	logic                   eff_bnd;
	logic [LSVR_PCNT_W-1:0] pcnt_b, pcnt_nx;
	logic [LSVR_SCNT_W-1:0] scnt_b, scnt_nx;
	lsvr_psum_t             psum_b  [3];
	lsvr_psum_t             psum_nx [3];
	lsvr_ssum_t             ssum_b  [3];
	lsvr_ssum_t             ssum_nx [3];
	lsvr_coord_t            first_b [3];
	lsvr_coord_t            first_nx[3];
	lsvr_coord_t            last_nx [3];
	lsvr_coord_t            pt      [3];

	logic                   over_val;
	logic [IDX_W-1:0]       w_idx;
	logic [WEIGHT_FRAC_BITS-1:0] w_rom;
	logic [NW_W-1:0]        nw;

	assign point.ready = !q_full;
	assign accept      = point.valid && point.ready;
	assign q_push      = accept && point.group_end;

	assign pt[0] = point.px;
	assign pt[1] = point.py;
	assign pt[2] = point.pz;

	// Next accumulator values for the current word
	always_comb begin
		first_item = !in_group_q;
		eff_mode   = first_item ? point.mode : mode_q;
		eff_bnd    = first_item ? point.on_boundary : bnd_q;
		pcnt_b     = first_item ? '0 : pcnt_q;
		scnt_b     = first_item ? '0 : scnt_q;
		for (int i = 0; i < 3; i++) begin
			psum_b[i]  = first_item ? '0 : psum_q[i];
			ssum_b[i]  = first_item ? '0 : ssum_q[i];
			first_b[i] = first_item ? '0 : first_q[i];
		end
		pcnt_nx = pcnt_b;
		scnt_nx = scnt_b;
		for (int i = 0; i < 3; i++) begin
			psum_nx[i]  = psum_b[i];
			ssum_nx[i]  = ssum_b[i];
			first_nx[i] = first_b[i];
			last_nx[i]  = first_item ? '0 : last_q[i];
		end
		if (!point.role) begin
			if (pcnt_b < LSVR_PCNT_W'(2)) begin
				for (int i = 0; i < 3; i++)
					psum_nx[i] = psum_b[i] + LSVR_PSUM_W'(pt[i]);
			end
			if (pcnt_b != LSVR_PCNT_W'(3))
				pcnt_nx = pcnt_b + LSVR_PCNT_W'(1);
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (scnt_b == '0)
					first_nx[i] = pt[i];
				last_nx[i] = pt[i];
				if (scnt_b < LSVR_SCNT_W'(MAX_VALENCE))
					ssum_nx[i] = ssum_b[i] + LSVR_SSUM_W'(pt[i]);
			end
			if (scnt_b != {LSVR_SCNT_W{1'b1}})
				scnt_nx = scnt_b + LSVR_SCNT_W'(1);
		end
	end

	// Weight lookup and center weight
	always_comb begin
		over_val = scnt_nx > LSVR_SCNT_W'(MAX_VALENCE);
		w_idx    = over_val ? '0 : scnt_nx[IDX_W-1:0];
		w_rom    = rom[w_idx];
		nw       = w_idx * w_rom;
	end

	// Group classification
	always_comb begin
		q_job.status = ST_OK;
		q_job.op     = OP_ZERO;
		if (!eff_mode) begin
			if (pcnt_nx != LSVR_PCNT_W'(1))
				q_job.status = ST_MALFORMED;
			else if (!algo_sel)
				q_job.op = OP_PASS;
			else if (eff_bnd) begin
				if (scnt_nx == '0)
					q_job.status = ST_MALFORMED;
				else
					q_job.op = OP_BOUND;
			end else if (over_val)
				q_job.status = ST_VALENCE;
			else
				q_job.op = OP_INTERIOR;
		end else begin
			if (pcnt_nx != LSVR_PCNT_W'(2))
				q_job.status = ST_MALFORMED;
			else if (!algo_sel || eff_bnd)
				q_job.op = OP_MID;
			else if (scnt_nx != LSVR_SCNT_W'(2))
				q_job.status = ST_MALFORMED;
			else
				q_job.op = OP_ODD;
		end
		for (int i = 0; i < 3; i++) begin
			q_job.psum[i]  = psum_nx[i];
			q_job.ssum[i]  = ssum_nx[i];
			q_job.first[i] = first_nx[i];
			q_job.last[i]  = last_nx[i];
		end
		q_job.w  = LSVR_WGT_W'(w_rom);
		q_job.wc = LSVR_WGT_W'(1 << WEIGHT_FRAC_BITS) - LSVR_WGT_W'(nw);
	end

	// Group open flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_group_q <= 1'b0;
		end else if (accept) begin
			in_group_q <= !point.group_end;
		end
	end

	// Accumulators
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= eff_mode;
			bnd_q  <= eff_bnd;
			pcnt_q <= pcnt_nx;
			scnt_q <= scnt_nx;
			for (int i = 0; i < 3; i++) begin
				psum_q[i]  <= psum_nx[i];
				ssum_q[i]  <= ssum_nx[i];
				first_q[i] <= first_nx[i];
				last_q[i]  <= last_nx[i];
			end
		end
	end

endmodule

// File: rtl/lsvr_queue.sv
// Short queue of classified groups between front and back ends.
module lsvr_queue import lsvr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lsvr_job_t push_job,
	output logic      full,
	input  logic      pop,
	output lsvr_job_t pop_job,
	output logic      empty
);

	localparam int PTR_W = $clog2(LSVR_QDEPTH);

	lsvr_job_t        mem_q [LSVR_QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full    = cnt_q == (PTR_W + 1)'(LSVR_QDEPTH);
	assign empty   = cnt_q == '0;
	assign pop_job = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (PTR_W + 1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (PTR_W + 1)'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

endmodule

// File: rtl/lsvr_back.sv
// Back end: weights, rounds and saturates one group per cycle while the vertex side takes its output.
module lsvr_back import lsvr_pkg::*; #(
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  lsvr_job_t job,
	input  logic      job_valid,
	output logic      job_pop,
	lsvr_out_if.source vertex
);

	localparam int PW_W = LSVR_PSUM_W + LSVR_WGT_W;
	localparam int SW_W = LSVR_SSUM_W + LSVR_WGT_W;

	logic         v_s1, v_s2;
	logic         en_s1, en_s2;
	lsvr_acc_t    a_s1  [3];
	lsvr_acc_t    b_s1  [3];
	lsvr_shift_t  sh_s1;
	lsvr_status_t st_s1;
	lsvr_coord_t  r_s2  [3];
	lsvr_status_t st_s2;

	logic signed [PW_W-1:0] pw [3];
	logic signed [SW_W-1:0] sw [3];
	lsvr_acc_t   a_nx [3];
	lsvr_acc_t   b_nx [3];
	lsvr_acc_t   p_ext[3];
	lsvr_acc_t   s_ext[3];
	lsvr_shift_t sh_nx;
	lsvr_acc_t   sum  [3];
	lsvr_acc_t   tmp  [3];
	lsvr_acc_t   rnd  [3];
	lsvr_coord_t sat  [3];

	// Stall control
	assign en_s2   = !v_s2 || vertex.ready;
	assign en_s1   = !v_s1 || en_s2;
	assign job_pop = job_valid && en_s1;

	// Stage 1: weighting terms
	always_comb begin
		sh_nx = SH_0;
		for (int i = 0; i < 3; i++) begin
			pw[i]    = $signed(job.psum[i]) * job.wc;
			sw[i]    = $signed(job.ssum[i]) * job.w;
			p_ext[i] = lsvr_acc_t'($signed(job.psum[i]));
			s_ext[i] = lsvr_acc_t'($signed(job.ssum[i]));
			a_nx[i]  = '0;
			b_nx[i]  = '0;
			case (job.op)
				OP_PASS: begin
					a_nx[i] = p_ext[i];
				end
				OP_BOUND: begin
					a_nx[i] = (p_ext[i] <<< 2) + (p_ext[i] <<< 1);
					b_nx[i] = lsvr_acc_t'($signed(job.first[i]))
						+ lsvr_acc_t'($signed(job.last[i]));
				end
				OP_INTERIOR: begin
					a_nx[i] = lsvr_acc_t'(pw[i]);
					b_nx[i] = lsvr_acc_t'(sw[i]);
				end
				OP_MID: begin
					a_nx[i] = p_ext[i];
				end
				OP_ODD: begin
					a_nx[i] = (p_ext[i] <<< 1) + p_ext[i];
					b_nx[i] = s_ext[i];
				end
				default: begin
					a_nx[i] = '0;
				end
			endcase
		end
		case (job.op)
			OP_BOUND:    sh_nx = SH_3;
			OP_INTERIOR: sh_nx = SH_F;
			OP_MID:      sh_nx = SH_1;
			OP_ODD:      sh_nx = SH_3;
			default:     sh_nx = SH_0;
		endcase
	end

	// Stage 2: add, round to nearest (ties up), saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = a_s1[i] + b_s1[i];
			case (sh_s1)
				SH_1: begin
					tmp[i] = sum[i] + lsvr_acc_t'(1);
					rnd[i] = tmp[i] >>> 1;
				end
				SH_3: begin
					tmp[i] = sum[i] + lsvr_acc_t'(4);
					rnd[i] = tmp[i] >>> 3;
				end
				SH_F: begin
					tmp[i] = sum[i] + (lsvr_acc_t'(1) <<< (WEIGHT_FRAC_BITS - 1));
					rnd[i] = tmp[i] >>> WEIGHT_FRAC_BITS;
				end
				default: begin
					tmp[i] = sum[i];
					rnd[i] = tmp[i];
				end
			endcase
			if (rnd[i] > LSVR_SAT_MAX)
				sat[i] = LSVR_SAT_MAX[LSVR_COORD_W-1:0];
			else if (rnd[i] < LSVR_SAT_MIN)
				sat[i] = LSVR_SAT_MIN[LSVR_COORD_W-1:0];
			else
				sat[i] = rnd[i][LSVR_COORD_W-1:0];
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1)
				v_s1 <= job_valid;
			if (en_s2)
				v_s2 <= v_s1;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (job_pop) begin
			a_s1  <= a_nx;
			b_s1  <= b_nx;
			sh_s1 <= sh_nx;
			st_s1 <= job.status;
		end
		if (en_s2 && v_s1) begin
			r_s2  <= sat;
			st_s2 <= st_s1;
		end
	end

	assign vertex.valid  = v_s2;
	assign vertex.rx     = r_s2[0];
	assign vertex.ry     = r_s2[1];
	assign vertex.rz     = r_s2[2];
	assign vertex.status = st_s2;

endmodule

// File: rtl/loop_subdivision_vertex_rules_core.sv
// Top level: Loop subdivision vertex rules core.
// Throughput: one point word per cycle unless the group queue is full; at most one vertex word per cycle.
// A vertex follows its group_end word through the group queue write, the weighting
// stage and the round/saturate output register.
// A four-entry group queue lets the point side run while the vertex side stalls.
// Reset (arst_n low, async): group closed, queue and pipeline empty, mode Loop.
module loop_subdivision_vertex_rules_core import lsvr_pkg::*; #(
	parameter int MAX_VALENCE      = 32,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	lsvr_in_if.sink    point,
	lsvr_out_if.source vertex
);

	logic      algo_sel_q;
	logic      q_full, q_empty, q_push, q_pop;
	lsvr_job_t q_in_job, q_out_job;

	// Algorithm select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			algo_sel_q <= 1'b1;
		end else if (cfg_wr_en) begin
			algo_sel_q <= cfg_wr_data;
		end
	end

	lsvr_front #(
		.MAX_VALENCE      (MAX_VALENCE),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.point    (point),
		.algo_sel (algo_sel_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_in_job)
	);

	lsvr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (q_out_job),
		.empty    (q_empty)
	);

	lsvr_back #(
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (q_out_job),
		.job_valid (!q_empty),
		.job_pop   (q_pop),
		.vertex    (vertex)
	);

endmodule
